### rtl/pll_divider_search_core_defines.svh
// Assertion macros shared by the PLL divider search RTL.
`ifndef PLL_DIVIDER_SEARCH_CORE_DEFINES_SVH
`define PLL_DIVIDER_SEARCH_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PDS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define PDS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define PDS_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PDS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/pds_pkg.sv
// Types and constants shared by the PLL divider search modules.
package pds_pkg;

  localparam logic [1:0] REG_REF_FREQ = 2'd0;
  localparam logic [1:0] REG_VCO_MIN  = 2'd1;
  localparam logic [1:0] REG_VCO_MAX  = 2'd2;

  localparam logic [26:0] REF_FREQ_RESET = 27'd14318180;
  localparam logic [19:0] VCO_MIN_RESET  = 20'd240000;
  localparam logic [19:0] VCO_MAX_RESET  = 20'd480000;

  localparam logic [9:0]  KHZ_TO_HZ  = 10'd1000;
  localparam logic [35:0] ERR_START  = 36'd1000000000;
  localparam logic [35:0] ERR_DONE   = 36'd1000;
  localparam logic [3:0]  N_MIN      = 4'd2;
  localparam logic [3:0]  N_MAX      = 4'd15;
  localparam logic [2:0]  D_MAX      = 3'd6;
  localparam logic [2:0]  OD_LIMIT   = 3'd3;
  localparam logic [7:0]  M_MIN      = 8'd2;
  localparam logic [3:0]  STEP_LAST  = 4'd8;

  typedef struct packed {
    logic [26:0] ref_freq_hz;
    logic [19:0] vco_min_khz;
    logic [19:0] vco_max_khz;
  } cfg_t;

  typedef struct packed {
    logic       load;
    logic       num_start;
    logic       mdiv_step;
    logic       vmul;
    logic       vdiv_step;
    logic       vcmp;
    logic       upd;
    logic       out_load;
    logic [3:0] shift;
    logic [2:0] d;
    logic [3:0] n;
  } cmd_t;

  typedef struct packed {
    logic m_ok;
    logic hit;
  } dp_flags_t;

endpackage

### rtl/pds_datapath.sv
// Datapath of the PLL divider search: M and VCO dividers, error compare, best keeper.
module pds_datapath (
  input  logic                 clk,
  input  pds_pkg::cfg_t        cfg,
  input  pds_pkg::cmd_t        cmd,
  input  logic [18:0]          req_khz,
  output pds_pkg::dp_flags_t   status,
  output logic                 found,
  output logic [7:0]           mult_m,
  output logic [3:0]           div_n,
  output logic [2:0]           post_div_log2,
  output logic [1:0]           od_code,
  output logic [1:0]           pod_code,
  output logic [17:0]          pll_word
);

  logic [28:0] target_hz;
  logic [29:0] lo_hz;
  logic [29:0] hi_hz;
  logic [39:0] num;
  logic [8:0]  mq;
  logic [35:0] vq;
  logic [3:0]  vrem;
  logic [35:0] err;
  logic        in_win;
  logic [35:0] best_err;
  logic        best_valid;
  logic [7:0]  best_m;
  logic [3:0]  best_n;
  logic [2:0]  best_d;

  logic [35:0] t2;
  logic [39:0] num_calc;
  logic [39:0] dsh;
  logic [27:0] den;
  logic [35:0] vq_step;
  logic [3:0]  vrem_step;
  logic [4:0]  r5;
  logic [35:0] actual;
  logic [35:0] err_calc;
  logic        in_win_calc;
  logic [1:0]  od_calc;
  logic [1:0]  pod_calc;

  // Numerator of the rounded M: 2 * target * 2^d * n + ref.
  always_comb begin
    t2       = 36'({target_hz, 1'b0}) << cmd.d;
    num_calc = (40'(t2) * 40'(cmd.n)) + 40'(cfg.ref_freq_hz);
    den      = {cfg.ref_freq_hz, 1'b0};
    dsh      = 40'(den) << cmd.shift;
  end

  // Four quotient bits of the VCO division by n per step.
  always_comb begin
    vq_step   = vq;
    vrem_step = vrem;
    r5        = '0;
    for (int k = 0; k < 4; k++) begin
      r5      = {vrem_step, vq_step[35]};
      vq_step = {vq_step[34:0], 1'b0};
      if (r5 >= {1'b0, cmd.n}) begin
        r5         = r5 - {1'b0, cmd.n};
        vq_step[0] = 1'b1;
      end
      vrem_step = r5[3:0];
    end
  end

  always_comb begin
    in_win_calc = (vq >= 36'(lo_hz)) && (vq <= 36'(hi_hz));
    actual      = vq >> cmd.d;
    err_calc    = (actual >= 36'(target_hz)) ? (actual - 36'(target_hz))
                                             : (36'(target_hz) - actual);
    od_calc     = (best_d > pds_pkg::OD_LIMIT) ? 2'(pds_pkg::OD_LIMIT) : best_d[1:0];
    pod_calc    = (best_d > pds_pkg::OD_LIMIT) ? 2'(best_d - pds_pkg::OD_LIMIT) : 2'd0;
  end

  assign status.m_ok = !mq[8] && (mq[7:1] != 7'd0);
  assign status.hit  = in_win && (err < pds_pkg::ERR_DONE);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      target_hz  <= 29'(29'(req_khz) * 29'(pds_pkg::KHZ_TO_HZ));
      lo_hz      <= 30'(30'(cfg.vco_min_khz) * 30'(pds_pkg::KHZ_TO_HZ));
      hi_hz      <= 30'(30'(cfg.vco_max_khz) * 30'(pds_pkg::KHZ_TO_HZ));
      best_err   <= pds_pkg::ERR_START;
      best_valid <= 1'b0;
    end
    if (cmd.num_start) begin
      num <= num_calc;
      mq  <= '0;
    end
    // Restoring division; a set top bit means M is 256 or more.
    if (cmd.mdiv_step) begin
      if (num >= dsh) begin
        num <= num - dsh;
        mq  <= {mq[7:0], 1'b1};
      end else begin
        mq  <= {mq[7:0], 1'b0};
      end
    end
    if (cmd.vmul) begin
      vq   <= 36'(36'(cfg.ref_freq_hz) * 36'(mq[7:0]));
      vrem <= '0;
    end
    if (cmd.vdiv_step) begin
      vq   <= vq_step;
      vrem <= vrem_step;
    end
    if (cmd.vcmp) begin
      in_win <= in_win_calc;
      err    <= err_calc;
    end
    if (cmd.upd && in_win && (err < best_err)) begin
      best_err   <= err;
      best_valid <= 1'b1;
      best_m     <= mq[7:0];
      best_n     <= cmd.n;
      best_d     <= cmd.d;
    end
    if (cmd.out_load) begin
      found <= best_valid;
      if (best_valid) begin
        mult_m        <= best_m;
        div_n         <= best_n;
        post_div_log2 <= best_d;
        od_code       <= od_calc;
        pod_code      <= pod_calc;
        pll_word      <= {1'b1, 1'b0, pod_calc, od_calc, best_n, best_m};
      end else begin
        mult_m        <= '0;
        div_n         <= '0;
        post_div_log2 <= '0;
        od_code       <= '0;
        pod_code      <= '0;
        pll_word      <= '0;
      end
    end
  end

endmodule

### rtl/pds_ctrl.sv
// Controller of the PLL divider search: candidate loop, divider step counts, handshakes.
module pds_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pds_pkg::dp_flags_t status,
  output pds_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_NUM, S_MDIV, S_MCHK, S_VMUL, S_VDIV, S_VCMP, S_UPD, S_FIN
  } state_t;

  state_t     state;
  logic [2:0] d;
  logic [3:0] n;
  logic [3:0] step;
  logic       last_cand;
  logic       out_free;

  assign in_ready  = (state == S_IDLE);
  assign last_cand = (n == pds_pkg::N_MAX) && (d == pds_pkg::D_MAX);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    cmd           = '0;
    cmd.d         = d;
    cmd.n         = n;
    cmd.shift     = step;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.num_start = (state == S_NUM);
    cmd.mdiv_step = (state == S_MDIV);
    cmd.vmul      = (state == S_VMUL);
    cmd.vdiv_step = (state == S_VDIV);
    cmd.vcmp      = (state == S_VCMP);
    cmd.upd       = (state == S_UPD);
    cmd.out_load  = (state == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      d         <= '0;
      n         <= pds_pkg::N_MIN;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            d     <= '0;
            n     <= pds_pkg::N_MIN;
            state <= S_NUM;
          end
        end
        S_NUM: begin
          step  <= pds_pkg::STEP_LAST;
          state <= S_MDIV;
        end
        S_MDIV: begin
          step <= step - 4'd1;
          if (step == 4'd0) begin
            state <= S_MCHK;
          end
        end
        S_MCHK: begin
          if (status.m_ok) begin
            state <= S_VMUL;
          end else if (last_cand) begin
            state <= S_FIN;
          end else begin
            state <= S_NUM;
            if (n == pds_pkg::N_MAX) begin
              n <= pds_pkg::N_MIN;
              d <= d + 3'd1;
            end else begin
              n <= n + 4'd1;
            end
          end
        end
        S_VMUL: begin
          step  <= pds_pkg::STEP_LAST;
          state <= S_VDIV;
        end
        S_VDIV: begin
          step <= step - 4'd1;
          if (step == 4'd0) begin
            state <= S_VCMP;
          end
        end
        S_VCMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          // An in-window error under 1 kHz ends the search at once.
          if (status.hit || last_cand) begin
            state <= S_FIN;
          end else begin
            state <= S_NUM;
            if (n == pds_pkg::N_MAX) begin
              n <= pds_pkg::N_MIN;
              d <= d + 3'd1;
            end else begin
              n <= n + 4'd1;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/pll_divider_search_core.sv
// PLL divider search top level: configuration registers, controller and datapath.
// One request at a time: a candidate (d, N) runs only the 9-step M division when M is out of
// range, and both the 9-step M division and the 9-step VCO division otherwise.
// At most 98 candidates are tried, with an early stop on an in-window error below 1 kHz.
// A new request is taken while the previous result waits in the output register.
// Synchronous reset returns the controller to idle and the configuration registers to their defaults.
`include "pll_divider_search_core_defines.svh"
module pll_divider_search_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [18:0] req_khz,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [7:0]  mult_m,
  output logic [3:0]  div_n,
  output logic [2:0]  post_div_log2,
  output logic [1:0]  od_code,
  output logic [1:0]  pod_code,
  output logic [17:0] pll_word,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [26:0] cfg_data
);

  pds_pkg::cfg_t      cfg;
  pds_pkg::cmd_t      cmd;
  pds_pkg::dp_flags_t status;
  logic               result_zero;
  logic               fields_ok;
  logic               split_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_freq_hz <= pds_pkg::REF_FREQ_RESET;
      cfg.vco_min_khz <= pds_pkg::VCO_MIN_RESET;
      cfg.vco_max_khz <= pds_pkg::VCO_MAX_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pds_pkg::REG_REF_FREQ: cfg.ref_freq_hz <= cfg_data;
        pds_pkg::REG_VCO_MIN:  cfg.vco_min_khz <= cfg_data[19:0];
        pds_pkg::REG_VCO_MAX:  cfg.vco_max_khz <= cfg_data[19:0];
        default: begin
        end
      endcase
    end
  end

  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pds_datapath u_datapath (
    .clk           (clk),
    .cfg           (cfg),
    .cmd           (cmd),
    .req_khz       (req_khz),
    .status        (status),
    .found         (found),
    .mult_m        (mult_m),
    .div_n         (div_n),
    .post_div_log2 (post_div_log2),
    .od_code       (od_code),
    .pod_code      (pod_code),
    .pll_word      (pll_word)
  );

  assign result_zero = (pll_word == 18'd0) && (mult_m == 8'd0) && (div_n == 4'd0) &&
                       (post_div_log2 == 3'd0);
  assign fields_ok   = pll_word[17] && (mult_m >= pds_pkg::M_MIN) &&
                       (div_n >= pds_pkg::N_MIN) && (pll_word[7:0] == mult_m);
  assign split_ok    = ((post_div_log2 <= pds_pkg::OD_LIMIT) &&
                        (od_code == post_div_log2[1:0]) && (pod_code == 2'd0)) ||
                       ((post_div_log2 > pds_pkg::OD_LIMIT) && (od_code == 2'd3) &&
                        (pod_code == 2'(post_div_log2 - pds_pkg::OD_LIMIT)));

  `PDS_ASSERT_NEXT(a_busy_after_request, clk, rst, in_valid && in_ready, !in_ready)
  `PDS_ASSERT_NOW(a_empty_result, clk, rst, out_valid && !found, result_zero)
  `PDS_ASSERT_NOW(a_found_result, clk, rst, out_valid && found, fields_ok)
  `PDS_ASSERT_NOW(a_divider_split, clk, rst, out_valid && found, split_ok)

endmodule
